[design/rmmst_pkg.sv]
`timescale 1ns / 1ps

package rmmst_pkg;

  // Store geometry
  localparam int LEAVES  = 1024;
  localparam int PAD     = 1 << $clog2(LEAVES);
  localparam int NODES   = 2 * PAD;
  localparam int NODE_W  = $clog2(NODES);
  localparam int SPAN_W  = NODE_W + 1;

  // Field widths
  localparam int POS_W   = 10;
  localparam int END_W   = 11;
  localparam int KEY_W   = 64;

  typedef logic [KEY_W-1:0] key_t;

  // Values are kept as order-preserving keys (value xor sign bit)
  localparam key_t SIGN_KEY      = {1'b1, {(KEY_W-1){1'b0}}};
  localparam key_t KEY_MIN_RESET = {KEY_W{1'b1}};
  localparam key_t KEY_MAX_RESET = {{(KEY_W-1){1'b0}}, 1'b1};

  // Command and status codes
  localparam logic CMD_UPDATE       = 1'b0;
  localparam logic CMD_QUERY        = 1'b1;
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_RANGE = 1'b1;

  typedef struct packed {
    key_t max_key;
    key_t min_key;
  } node_t;

  localparam node_t RESET_NODE = '{max_key: KEY_MAX_RESET, min_key: KEY_MIN_RESET};

  typedef struct packed {
    logic                    cmd;
    logic [POS_W-1:0]        position;
    logic [END_W-1:0]        end_pos;
    logic signed [KEY_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] range_min;
    logic signed [KEY_W-1:0] range_max;
    logic                    status;
  } rsp_t;

  function automatic key_t key_min(input key_t a, input key_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic key_t key_max(input key_t a, input key_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

[design/range_min_max_segment_tree.sv]
// Range minimum/maximum store over 1024 signed 64-bit leaves, built as two
// segment trees (minima and maxima) kept side by side in one on-chip memory
// of 2048 node entries, with one write port and two read ports whose read
// data is registered. An item with tuser = 0 writes new_value to the leaf
// at position and rebuilds all ten ancestors, one per cycle (read sibling,
// merge, write parent); it returns a zero acknowledge. An item with
// tuser = 1 returns the minimum and maximum over [position, end_pos),
// walking the tree bottom-up with up to two node reads per level; an empty,
// reversed or out-of-bounds range returns status 1 with zero data. One item
// is in work at a time, and its result is loaded into the output register.
// The output register lets the next item enter while a result waits. After
// reset the block runs a clearing pass over all 2048 node entries, one per
// cycle, and holds s_axis_tready low until it ends.
`timescale 1ns / 1ps

module range_min_max_segment_tree (
  input  logic         clk,
  input  logic         rst,
  // Input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,  // position[9:0], end_pos[20:10], new_value[84:21], zero
  input  logic         s_axis_tuser,  // cmd
  // Result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // range_min[63:0], range_max[127:64]
  output logic         m_axis_tuser   // status
);
  import rmmst_pkg::*;

  req_t req;
  rsp_t rsp;
  logic rsp_valid;
  logic out_free;

  // Unpack the input item
  assign req.cmd       = s_axis_tuser;
  assign req.position  = s_axis_tdata[9:0];
  assign req.end_pos   = s_axis_tdata[20:10];
  assign req.new_value = $signed(s_axis_tdata[84:21]);

  // Output register takes a result when empty or being drained
  assign out_free = !m_axis_tvalid || m_axis_tready;

  rmmst_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (out_free),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (rsp_valid && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Load the payload with each delivered result; hold it otherwise
  always_ff @(posedge clk) begin
    if (rsp_valid && out_free) begin
      m_axis_tdata <= {rsp.range_max, rsp.range_min};
      m_axis_tuser <= rsp.status;
    end
  end

endmodule

[design/rmmst_engine.sv]
`timescale 1ns / 1ps

module rmmst_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  rmmst_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output rmmst_pkg::rsp_t rsp
);
  import rmmst_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_QRY   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Node store: one write port, two read ports, registered read data
  node_t tree_mem [NODES];

  logic              we;
  logic [NODE_W-1:0] waddr;
  node_t             wdata;
  logic [NODE_W-1:0] raddr_a;
  logic [NODE_W-1:0] raddr_b;
  node_t             rdata_a;
  node_t             rdata_b;

  always_ff @(posedge clk) begin
    if (we) begin
      tree_mem[waddr] <= wdata;
    end
    rdata_a <= tree_mem[raddr_a];
    rdata_b <= tree_mem[raddr_b];
  end

  logic [2:0]        state, state_next;
  logic [NODE_W-1:0] clr_addr, clr_addr_next;
  logic [NODE_W-1:0] node, node_next;
  node_t             cur, cur_next;
  logic [SPAN_W-1:0] lo, lo_next;
  logic [SPAN_W-1:0] hi, hi_next;
  key_t              kmin, kmin_next;
  key_t              kmax, kmax_next;
  logic              pend_a, pend_a_next;
  logic              pend_b, pend_b_next;
  rsp_t              rsp_next;

  logic [NODE_W-1:0] leaf_addr;
  logic [NODE_W-1:0] parent;
  node_t             merged;
  key_t              new_key;
  key_t              amin_a, amax_a, amin, amax;
  logic              bad_range;
  logic [SPAN_W-1:0] hi_dec;

  assign leaf_addr = NODE_W'(PAD) + NODE_W'(req.position);
  assign new_key   = req.new_value ^ SIGN_KEY;
  assign bad_range = ({1'b0, req.position} >= req.end_pos) || (32'(req.end_pos) > LEAVES);
  assign parent    = node >> 1;
  assign hi_dec    = hi - SPAN_W'(1);

  // Merge the carried node with its sibling read back from the store
  assign merged.min_key = key_min(cur.min_key, rdata_a.min_key);
  assign merged.max_key = key_max(cur.max_key, rdata_a.max_key);

  // Absorb the nodes read in the previous query step
  assign amin_a = pend_a ? key_min(kmin, rdata_a.min_key) : kmin;
  assign amax_a = pend_a ? key_max(kmax, rdata_a.max_key) : kmax;
  assign amin   = pend_b ? key_min(amin_a, rdata_b.min_key) : amin_a;
  assign amax   = pend_b ? key_max(amax_a, rdata_b.max_key) : amax_a;

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_DONE);

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    node_next     = node;
    cur_next      = cur;
    lo_next       = lo;
    hi_next       = hi;
    kmin_next     = kmin;
    kmax_next     = kmax;
    pend_a_next   = 1'b0;
    pend_b_next   = 1'b0;
    rsp_next      = rsp;
    we            = 1'b0;
    waddr         = '0;
    wdata         = RESET_NODE;
    raddr_a       = '0;
    raddr_b       = '0;

    unique case (state)
      ST_CLEAR: begin
        we            = 1'b1;
        waddr         = clr_addr;
        wdata         = RESET_NODE;
        clr_addr_next = clr_addr + NODE_W'(1);
        if (clr_addr == {NODE_W{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_valid) begin
          rsp_next = '0;
          if (req.cmd == CMD_UPDATE) begin
            if (32'(req.position) < LEAVES) begin
              // Write the leaf and fetch its sibling
              we         = 1'b1;
              waddr      = leaf_addr;
              wdata      = '{max_key: new_key, min_key: new_key};
              raddr_a    = leaf_addr ^ NODE_W'(1);
              node_next  = leaf_addr;
              cur_next   = '{max_key: new_key, min_key: new_key};
              state_next = ST_UPD;
            end else begin
              rsp_next.status = STATUS_OK;
              state_next      = ST_DONE;
            end
          end else if (bad_range) begin
            rsp_next.status = STATUS_BAD_RANGE;
            state_next      = ST_DONE;
          end else begin
            lo_next    = SPAN_W'(PAD) + SPAN_W'(req.position);
            hi_next    = SPAN_W'(PAD) + SPAN_W'(req.end_pos);
            kmin_next  = KEY_MIN_RESET;
            kmax_next  = '0;
            state_next = ST_QRY;
          end
        end
      end

      ST_UPD: begin
        // Write the parent, fetch the parent's sibling
        we        = 1'b1;
        waddr     = parent;
        wdata     = merged;
        raddr_a   = parent ^ NODE_W'(1);
        node_next = parent;
        cur_next  = merged;
        if (parent == NODE_W'(1)) begin
          rsp_next   = '0;
          state_next = ST_DONE;
        end
      end

      ST_QRY: begin
        kmin_next = amin;
        kmax_next = amax;
        if (lo < hi) begin
          raddr_a     = lo[NODE_W-1:0];
          raddr_b     = hi_dec[NODE_W-1:0];
          pend_a_next = lo[0];
          pend_b_next = hi[0];
          lo_next     = (lo + SPAN_W'(lo[0])) >> 1;
          hi_next     = hi >> 1;
        end else begin
          rsp_next.range_min = $signed(amin ^ SIGN_KEY);
          rsp_next.range_max = $signed(amax ^ SIGN_KEY);
          rsp_next.status    = STATUS_OK;
          state_next         = ST_DONE;
        end
      end

      ST_DONE: begin
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pend_a   <= 1'b0;
      pend_b   <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      pend_a   <= pend_a_next;
      pend_b   <= pend_b_next;
    end
  end

  always_ff @(posedge clk) begin
    node <= node_next;
    cur  <= cur_next;
    lo   <= lo_next;
    hi   <= hi_next;
    kmin <= kmin_next;
    kmax <= kmax_next;
    rsp  <= rsp_next;
  end

endmodule
